FILE: rtl/mspss_pkg.sv
// Package with the types, codes and constants shared by the speed controller files.
`timescale 1ns / 1ps
`default_nettype none

package mspss_pkg;

  // Defaults of the top level parameters.
  localparam int PWM_PERIOD_DEF   = 4096;
  localparam int STALL_PERIOD_DEF = 65000;
  localparam int RAMP_WINDOW_DEF  = 50;

  // Configuration register indexes.
  localparam logic [2:0] REG_PROP_GAIN   = 3'd0;
  localparam logic [2:0] REG_INTEG_GAIN  = 3'd1;
  localparam logic [2:0] REG_DERIV_GAIN  = 3'd2;
  localparam logic [2:0] REG_SPEED_TGT   = 3'd3;
  localparam logic [2:0] REG_RAMP_STEP   = 3'd4;
  localparam logic [2:0] REG_TIMER_CLOCK = 3'd5;
  localparam logic [2:0] REG_SPEED_LIMIT = 3'd6;

  // Register reset values.
  localparam logic [15:0] PROP_GAIN_RST   = 16'd12800;
  localparam logic [11:0] RAMP_STEP_RST   = 12'd10;
  localparam logic [23:0] TIMER_CLOCK_RST = 24'd1000000;
  localparam logic [15:0] SPEED_LIMIT_RST = 16'd65535;

  localparam int CFG_DATA_W = 24;

  // Event codes carried in the mode field.
  localparam logic [1:0] MODE_EDGE  = 2'd0;
  localparam logic [1:0] MODE_TICK  = 2'd1;
  localparam logic [1:0] MODE_START = 2'd2;
  localparam logic [1:0] MODE_STOP  = 2'd3;

  // Run phases.
  localparam logic [1:0] PH_STOP = 2'd0;
  localparam logic [1:0] PH_RAMP = 2'd1;
  localparam logic [1:0] PH_PID  = 2'd2;

  // Operand selects of the shared multiplier.
  localparam logic [2:0] MSEL_PROP   = 3'd0;
  localparam logic [2:0] MSEL_DERIV  = 3'd1;
  localparam logic [2:0] MSEL_INT_LO = 3'd2;
  localparam logic [2:0] MSEL_INT_HI = 3'd3;
  localparam logic [2:0] MSEL_SCALE  = 3'd4;

  // The divider retires two quotient bits per cycle over a 24 bit dividend.
  localparam int DIVIDEND_W = 24;
  localparam int DIV_CYCLES = DIVIDEND_W / 2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] edge_period;
    logic [15:0] start_duty;
  } mspss_in_t;

  typedef struct packed {
    logic [15:0] duty;
    logic [15:0] speed;
    logic [1:0]  phase;
  } mspss_out_t;

  typedef struct packed {
    logic       load;
    logic       simple;
    logic       div_step;
    logic       speed_set;
    logic       mul_en;
    logic [2:0] mul_sel;
    logic       acc_en;
    logic       acc_first;
    logic       pid_fin;
    logic       out_load;
  } mspss_cmd_t;

  typedef struct packed {
    logic [1:0] phase;
  } mspss_stat_t;

endpackage

`default_nettype wire

FILE: rtl/motor_speed_pid_soft_start.sv
// Motor speed controller with soft start ramp and PID regulation.
//
// The input channel (in_valid, in_ready, in_data) takes one event word: an
// encoder edge with its captured period, a control tick, a start command or
// a stop command. Every accepted word gives exactly one result word on the
// output channel (out_valid, out_ready, out_data) with the duty, the latest
// speed and the run phase after that event.
// One word is worked on at a time; in_ready is high when the block is idle.
// An encoder edge runs the divider, which retires two quotient bits per
// cycle; a control tick in PID regulation runs multiply and accumulate
// steps that push five products through the single 16 x 25 bit multiplier;
// every other word goes through the simple step. The result turns valid in
// the same cycle that in_ready returns. The result register holds a
// finished word while the receiver stalls; a further word is accepted and
// worked on, then waits until that register frees. Configuration writes
// take effect at once; the user must make them while idle, which the block
// does not enforce. Reset restores the register defaults, stops the motor
// and clears speed, duty, integral sum and previous error.
`timescale 1ns / 1ps
`default_nettype none

module motor_speed_pid_soft_start #(
  parameter int PWM_PERIOD   = mspss_pkg::PWM_PERIOD_DEF,
  parameter int STALL_PERIOD = mspss_pkg::STALL_PERIOD_DEF,
  parameter int RAMP_WINDOW  = mspss_pkg::RAMP_WINDOW_DEF
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               cfg_wr_en,
  input  wire  [2:0]                        cfg_index,
  input  wire  [mspss_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  mspss_pkg::mspss_in_t              in_data,
  output logic                              out_valid,
  input  wire                               out_ready,
  output mspss_pkg::mspss_out_t             out_data
);
  import mspss_pkg::*;

  mspss_cmd_t  cmd;
  mspss_stat_t stat;

  mspss_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_mode   (in_data.mode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mspss_dp #(
    .PWM_PERIOD   (PWM_PERIOD),
    .STALL_PERIOD (STALL_PERIOD),
    .RAMP_WINDOW  (RAMP_WINDOW)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

FILE: rtl/mspss_dp.sv
// Datapath: configuration registers, controller state, divider, multiplier and result register.
`timescale 1ns / 1ps
`default_nettype none

module mspss_dp #(
  parameter int PWM_PERIOD   = mspss_pkg::PWM_PERIOD_DEF,
  parameter int STALL_PERIOD = mspss_pkg::STALL_PERIOD_DEF,
  parameter int RAMP_WINDOW  = mspss_pkg::RAMP_WINDOW_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 cfg_wr_en,
  input  wire  [2:0]                          cfg_index,
  input  wire  [mspss_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  mspss_pkg::mspss_in_t                in_data,
  input  mspss_pkg::mspss_cmd_t               cmd,
  output mspss_pkg::mspss_stat_t              stat,
  output mspss_pkg::mspss_out_t               out_data
);
  import mspss_pkg::*;

  localparam logic [15:0] PWM_P   = 16'(PWM_PERIOD);
  localparam logic [15:0] STALL_P = 16'(STALL_PERIOD);
  localparam logic [16:0] RAMP_W  = 17'(RAMP_WINDOW);
  localparam logic signed [39:0] INTEG_MAX = {1'b0, {39{1'b1}}};
  localparam logic signed [39:0] INTEG_MIN = {1'b1, {39{1'b0}}};

  // Configuration registers.
  logic [15:0] prop_gain;
  logic [15:0] integ_gain_dt;
  logic [15:0] deriv_gain_over_dt;
  logic [15:0] speed_target;
  logic [11:0] ramp_step;
  logic [23:0] timer_clock;
  logic [15:0] speed_limit;

  // Controller state.
  logic [1:0]         phase_reg;
  logic [15:0]        duty_reg;
  logic [15:0]        speed_reg;
  logic signed [39:0] integral_sum;
  logic signed [16:0] previous_error;

  // Captured word and working registers.
  logic [1:0]         mode_q;
  logic [15:0]        period_q;
  logic [15:0]        start_duty_q;
  logic [15:0]        rem;
  logic [23:0]        quot;
  logic signed [41:0] prod;
  logic [2:0]         prod_sel;
  logic signed [57:0] acc;

  logic [15:0]        rem_next;
  logic [23:0]        quot_next;
  logic [16:0]        trial;
  logic [16:0]        diff;
  logic signed [16:0] err;
  logic signed [17:0] derr;
  logic [15:0]        mul_a;
  logic signed [24:0] mul_b;
  logic signed [57:0] prod_ext;
  logic signed [57:0] term;
  logic [16:0]        ramp_sum;
  logic [16:0]        ramp_upper;
  logic               in_window;
  logic               bad_period;
  logic signed [40:0] isum_new;

  assign stat.phase = phase_reg;

  assign err  = $signed({1'b0, speed_target}) - $signed({1'b0, speed_reg});
  assign derr = $signed({err[16], err}) - $signed({previous_error[16], previous_error});

  // Two restoring division steps per cycle.
  always_comb begin
    rem_next  = rem;
    quot_next = quot;
    trial     = '0;
    diff      = '0;
    for (int i = 0; i < 2; i++) begin
      trial = {rem_next, quot_next[23]};
      diff  = trial - {1'b0, period_q};
      if (trial >= {1'b0, period_q}) begin
        rem_next  = diff[15:0];
        quot_next = {quot_next[22:0], 1'b1};
      end else begin
        rem_next  = trial[15:0];
        quot_next = {quot_next[22:0], 1'b0};
      end
    end
  end

  // The integral term is split so that no product is wider than 16 x 25 bits.
  always_comb begin
    case (cmd.mul_sel)
      MSEL_PROP: begin
        mul_a = prop_gain;
        mul_b = {{8{err[16]}}, err};
      end
      MSEL_DERIV: begin
        mul_a = deriv_gain_over_dt;
        mul_b = {{7{derr[17]}}, derr};
      end
      MSEL_INT_LO: begin
        mul_a = integ_gain_dt;
        mul_b = {9'b0, integral_sum[15:0]};
      end
      MSEL_INT_HI: begin
        mul_a = integ_gain_dt;
        mul_b = {integral_sum[39], integral_sum[39:16]};
      end
      MSEL_SCALE: begin
        mul_a = PWM_P;
        mul_b = {9'b0, acc[31:16]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_ext = {{16{prod[41]}}, prod};

  always_comb begin
    case (prod_sel)
      MSEL_PROP, MSEL_DERIV: term = {prod_ext[49:0], 8'b0};
      MSEL_INT_LO:           term = prod_ext;
      MSEL_INT_HI:           term = {prod_ext[41:0], 16'b0};
      default:               term = '0;
    endcase
  end

  assign ramp_sum   = {1'b0, duty_reg} + {5'b0, ramp_step};
  assign ramp_upper = {1'b0, speed_target} + RAMP_W;
  assign in_window  = (speed_reg > speed_target) && ({1'b0, speed_reg} < ramp_upper);
  assign bad_period = (period_q == 16'd0) || (period_q >= STALL_P);
  assign isum_new   = {integral_sum[39], integral_sum} + {{24{err[16]}}, err};

  // Configuration and controller state.
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain          <= PROP_GAIN_RST;
      integ_gain_dt      <= '0;
      deriv_gain_over_dt <= '0;
      speed_target       <= '0;
      ramp_step          <= RAMP_STEP_RST;
      timer_clock        <= TIMER_CLOCK_RST;
      speed_limit        <= SPEED_LIMIT_RST;
      phase_reg          <= PH_STOP;
      duty_reg           <= '0;
      speed_reg          <= '0;
      integral_sum       <= '0;
      previous_error     <= '0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_PROP_GAIN:   prop_gain          <= cfg_data[15:0];
          REG_INTEG_GAIN:  integ_gain_dt      <= cfg_data[15:0];
          REG_DERIV_GAIN:  deriv_gain_over_dt <= cfg_data[15:0];
          REG_SPEED_TGT:   speed_target       <= cfg_data[15:0];
          REG_RAMP_STEP:   ramp_step          <= cfg_data[11:0];
          REG_TIMER_CLOCK: timer_clock        <= cfg_data[23:0];
          REG_SPEED_LIMIT: speed_limit        <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (cmd.simple) begin
        case (mode_q)
          MODE_START: begin
            duty_reg  <= (start_duty_q > PWM_P) ? PWM_P : start_duty_q;
            speed_reg <= '0;
            phase_reg <= PH_RAMP;
          end
          MODE_STOP: begin
            duty_reg       <= '0;
            speed_reg      <= '0;
            phase_reg      <= PH_STOP;
            integral_sum   <= '0;
            previous_error <= '0;
          end
          MODE_TICK: begin
            if (phase_reg == PH_RAMP) begin
              if (in_window) begin
                phase_reg <= PH_PID;
              end else begin
                duty_reg <= (ramp_sum > {1'b0, PWM_P}) ? PWM_P : ramp_sum[15:0];
              end
            end
          end
          default: ;
        endcase
      end
      if (cmd.speed_set) begin
        if (bad_period || (quot >= {8'b0, speed_limit})) begin
          speed_reg <= '0;
        end else begin
          speed_reg <= quot[15:0];
        end
      end
      if (cmd.pid_fin) begin
        // The output is zero below one unit; at or above 2^16 units it saturates.
        if (acc[57] || (acc[57:16] == '0)) begin
          duty_reg <= '0;
        end else if (acc[57:32] != '0) begin
          duty_reg <= PWM_P;
        end else begin
          duty_reg <= prod[31:16];
        end
        if (isum_new[40] != isum_new[39]) begin
          integral_sum <= isum_new[40] ? INTEG_MIN : INTEG_MAX;
        end else begin
          integral_sum <= isum_new[39:0];
        end
        previous_error <= err;
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q       <= in_data.mode;
      period_q     <= in_data.edge_period;
      start_duty_q <= in_data.start_duty;
      rem          <= '0;
      quot         <= timer_clock;
    end else if (cmd.div_step) begin
      rem  <= rem_next;
      quot <= quot_next;
    end
    if (cmd.mul_en) begin
      prod     <= $signed({1'b0, mul_a}) * mul_b;
      prod_sel <= cmd.mul_sel;
    end
    if (cmd.acc_en) begin
      acc <= cmd.acc_first ? term : acc + term;
    end
    if (cmd.out_load) begin
      out_data.duty  <= duty_reg;
      out_data.speed <= speed_reg;
      out_data.phase <= phase_reg;
    end
  end

  a_duty_limit: assert property (@(posedge clk) disable iff (rst) duty_reg <= PWM_P)
    else $error("duty above the PWM period");
  a_phase_code: assert property (@(posedge clk) disable iff (rst)
    phase_reg == PH_STOP || phase_reg == PH_RAMP || phase_reg == PH_PID)
    else $error("illegal run phase");
  a_stopped_clear: assert property (@(posedge clk) disable iff (rst)
    phase_reg == PH_STOP |-> duty_reg == '0 && integral_sum == '0 && previous_error == '0)
    else $error("stopped with regulator state left over");

endmodule

`default_nettype wire

FILE: rtl/mspss_ctrl.sv
// Controller state machine that sequences the divider, multiplier and result register.
`timescale 1ns / 1ps
`default_nettype none

module mspss_ctrl (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire  [1:0]              in_mode,
  output logic                    out_valid,
  input  wire                     out_ready,
  input  mspss_pkg::mspss_stat_t  stat,
  output mspss_pkg::mspss_cmd_t   cmd
);
  import mspss_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SIMPLE = 3'd1;
  localparam logic [2:0] S_DIV    = 3'd2;
  localparam logic [2:0] S_SPEED  = 3'd3;
  localparam logic [2:0] S_MUL    = 3'd4;
  localparam logic [2:0] S_PID    = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  localparam logic [3:0] DIV_LAST = 4'(DIV_CYCLES - 1);
  localparam logic [3:0] MUL_LAST = 4'd5;

  logic [2:0] state, state_next;
  logic [3:0] cnt, cnt_next;
  logic       out_valid_next;
  logic       in_acc;
  logic       out_free;

  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        cnt_next = '0;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_mode == MODE_EDGE) begin
            state_next = S_DIV;
          end else if (in_mode == MODE_TICK && stat.phase == PH_PID) begin
            state_next = S_MUL;
          end else begin
            state_next = S_SIMPLE;
          end
        end
      end
      S_SIMPLE: begin
        cmd.simple = 1'b1;
        state_next = S_OUT;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 4'd1;
        if (cnt == DIV_LAST) begin
          state_next = S_SPEED;
        end
      end
      S_SPEED: begin
        cmd.speed_set = 1'b1;
        state_next    = S_OUT;
      end
      S_MUL: begin
        // Each product is accumulated in the cycle after it is formed; the last
        // product scales the finished sum by the PWM period.
        cmd.mul_en    = (cnt != 4'd4);
        cmd.mul_sel   = (cnt == MUL_LAST) ? MSEL_SCALE : cnt[2:0];
        cmd.acc_en    = (cnt >= 4'd1) && (cnt <= 4'd4);
        cmd.acc_first = (cnt == 4'd1);
        cnt_next      = cnt + 4'd1;
        if (cnt == MUL_LAST) begin
          state_next = S_PID;
        end
      end
      S_PID: begin
        cmd.pid_fin = 1'b1;
        state_next  = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !out_valid || out_ready)
    else $error("result word overwritten before it was taken");
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> state != S_IDLE)
    else $error("accepted word did not start work");
  a_div_count: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> cnt <= DIV_LAST)
    else $error("divider step count out of range");

endmodule

`default_nettype wire
